[src/ntmr_pkg.sv]
package ntmr_pkg;

   // default table geometry
   localparam int MAX_NEURON_SLOTS      = 16;
   localparam int MAX_INPUTS_PER_NEURON = 32;

   // fixed field widths
   localparam int FUNC_W = 3;
   localparam int ID_W   = 8;
   localparam int CNT_W  = 6;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 16;
   localparam int STAT_W = 2;
   localparam int OUT_W  = 15;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 40;
   localparam int FRAC_W = 8;

   // item kinds
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEFINE  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNKNOWN   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic slot_step;
      logic exec;
      logic clr_step;
      logic mac_step;
      logic pos_start;
      logic pos_step;
      logic resp_load;
   } ntmr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_done;
      logic go_clr;
      logic go_mac;
      logic clr_done;
      logic mac_done;
      logic pos_done;
   } ntmr_stat_type;

endpackage

[src/ntmr_dp.sv]
module ntmr_dp #(
   parameter int NS = ntmr_pkg::MAX_NEURON_SLOTS,
   parameter int NI = ntmr_pkg::MAX_INPUTS_PER_NEURON
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ntmr_pkg::ntmr_cmd_type             cmd,
   output ntmr_pkg::ntmr_stat_type            stat,
   input  logic [ntmr_pkg::FUNC_W-1:0]        req_func,
   input  logic [ntmr_pkg::ID_W-1:0]          req_neuron_id,
   input  logic [ntmr_pkg::CNT_W-1:0]         req_input_count,
   input  logic [ntmr_pkg::POS_W-1:0]         req_position,
   input  logic [ntmr_pkg::ID_W-1:0]          req_source_id,
   input  logic signed [ntmr_pkg::VAL_W-1:0]  req_value,
   output logic [ntmr_pkg::STAT_W-1:0]        rsp_status,
   output logic [ntmr_pkg::OUT_W-1:0]         rsp_neuron_output,
   output logic [ntmr_pkg::CNT_W-1:0]         rsp_known_input_count,
   output logic                               rsp_input_required
);

   localparam int SW    = (NS > 1) ? $clog2(NS) : 1;
   localparam int CW    = $clog2(NS + 1);
   localparam int IXW   = $clog2(NI + 1);
   localparam int DEPTH = NS * NI;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMPW  = (IXW > ntmr_pkg::CNT_W) ? IXW : ntmr_pkg::CNT_W;
   localparam logic [CW-1:0]   NS_C  = CW'(NS);
   localparam logic [IXW-1:0]  NI_C  = IXW'(NI);
   localparam logic [AW-1:0]   NI_A  = AW'(NI);
   localparam logic [CMPW-1:0] NI_X  = CMPW'(NI);

   // latched item
   logic [ntmr_pkg::FUNC_W-1:0]       func_ff;
   logic [ntmr_pkg::ID_W-1:0]         nid_ff;
   logic [ntmr_pkg::CNT_W-1:0]        cnt_ff;
   logic [ntmr_pkg::POS_W-1:0]        pos_ff;
   logic [ntmr_pkg::ID_W-1:0]         src_ff;
   logic signed [ntmr_pkg::VAL_W-1:0] val_ff;

   // control and working registers
   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     sidx_ff;
   logic                              found_ff;
   logic [SW-1:0]                     slot_ff;
   logic [ntmr_pkg::STAT_W-1:0]       status_ff;
   logic [IXW-1:0]                    idx_ff;
   logic [IXW-1:0]                    piss_ff;
   logic [IXW-1:0]                    pidx_ff;
   logic                              pfound_ff;
   logic                              v1_ff;
   logic                              v2_ff;
   logic signed [ntmr_pkg::PROD_W-1:0] prod_ff;
   logic signed [ntmr_pkg::ACC_W-1:0]  acc_ff;

   // memory read data
   logic signed [ntmr_pkg::VAL_W-1:0] rd_val_ff;
   logic signed [ntmr_pkg::VAL_W-1:0] rd_w_ff;
   logic [ntmr_pkg::ID_W-1:0]         rd_src_ff;

   // output registers
   logic [ntmr_pkg::STAT_W-1:0]       out_status_ff;
   logic [ntmr_pkg::OUT_W-1:0]        out_result_ff;
   logic [ntmr_pkg::CNT_W-1:0]        out_known_ff;
   logic                              out_req_ff;

   // slot table in flops
   logic [ntmr_pkg::ID_W-1:0]         id_mem   [NS];
   logic [ntmr_pkg::CNT_W-1:0]        cnt_mem  [NS];
   logic signed [ntmr_pkg::VAL_W-1:0] bias_mem [NS];

   // per position memories
   logic signed [ntmr_pkg::VAL_W-1:0] w_mem [DEPTH];
   logic [ntmr_pkg::ID_W-1:0]         s_mem [DEPTH];
   logic signed [ntmr_pkg::VAL_W-1:0] v_mem [DEPTH];

   logic                              full;
   logic [ntmr_pkg::CNT_W-1:0]        slot_cnt;
   logic [IXW-1:0]                    lim;
   logic                              issue;
   logic [AW-1:0]                     off;
   logic [AW-1:0]                     addr;
   logic [ntmr_pkg::CNT_W-1:0]        cnt_sat;
   logic                              load_ok;
   logic                              set_ok;
   logic                              acc_pos;
   logic [ntmr_pkg::OUT_W-1:0]        result;
   logic signed [ntmr_pkg::PROD_W-1:0] mult;

   // shared lookups
   always_comb begin
      full     = (count_ff == NS_C);
      slot_cnt = cnt_mem[slot_ff];
      lim      = found_ff ? IXW'(slot_cnt) : '0;
      issue    = (idx_ff < lim);
      cnt_sat  = (CMPW'(req_input_count) > NI_X) ? ntmr_pkg::CNT_W'(NI) : req_input_count;
      load_ok  = found_ff && ({1'b0, pos_ff} < slot_cnt);
      set_ok   = (func_ff == ntmr_pkg::FUNC_SET) && found_ff && pfound_ff;
      mult     = rd_val_ff * rd_w_ff;
   end

   // address of slot row plus offset
   always_comb begin
      if (cmd.exec) begin
         off = AW'(pos_ff);
      end else if (cmd.resp_load) begin
         off = AW'(pidx_ff);
      end else begin
         off = AW'(idx_ff);
      end
      addr = AW'(slot_ff) * NI_A + off;
   end

   // saturated relu of the accumulator
   always_comb begin
      acc_pos = !acc_ff[ntmr_pkg::ACC_W-1] && (acc_ff != '0);
      if (!acc_pos) begin
         result = '0;
      end else if (|acc_ff[ntmr_pkg::ACC_W-2:ntmr_pkg::FRAC_W+ntmr_pkg::OUT_W]) begin
         result = '1;
      end else begin
         result = acc_ff[ntmr_pkg::FRAC_W+ntmr_pkg::OUT_W-1:ntmr_pkg::FRAC_W];
      end
   end

   // status to controller
   always_comb begin
      stat.slot_done = (sidx_ff >= count_ff);
      stat.go_clr    = (func_ff == ntmr_pkg::FUNC_DEFINE) && !full;
      stat.go_mac    = (func_ff == ntmr_pkg::FUNC_COMPUTE) && found_ff;
      stat.clr_done  = (idx_ff == NI_C);
      stat.mac_done  = !issue && !v1_ff && !v2_ff;
      stat.pos_done  = !issue && !v1_ff;
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         if (cmd.start) begin
            func_ff   <= req_func;
            nid_ff    <= req_neuron_id;
            cnt_ff    <= cnt_sat;
            pos_ff    <= req_position;
            src_ff    <= req_source_id;
            val_ff    <= req_value;
            sidx_ff   <= '0;
            found_ff  <= 1'b0;
            pfound_ff <= 1'b0;
            acc_ff    <= '0;
            status_ff <= ntmr_pkg::ST_OK;
         end
         // slot search, highest match wins
         if (cmd.slot_step) begin
            if (id_mem[sidx_ff[SW-1:0]] == nid_ff) begin
               found_ff <= 1'b1;
               slot_ff  <= sidx_ff[SW-1:0];
            end
            sidx_ff <= sidx_ff + 1'b1;
         end
         // apply the item
         if (cmd.exec) begin
            idx_ff <= '0;
            v1_ff  <= 1'b0;
            v2_ff  <= 1'b0;
            case (func_ff)
               ntmr_pkg::FUNC_CLEAR: begin
                  count_ff <= '0;
                  found_ff <= 1'b0;
               end
               ntmr_pkg::FUNC_DEFINE: begin
                  if (full) begin
                     status_ff <= ntmr_pkg::ST_FULL;
                  end else begin
                     slot_ff  <= count_ff[SW-1:0];
                     found_ff <= 1'b1;
                     count_ff <= count_ff + 1'b1;
                  end
               end
               ntmr_pkg::FUNC_LOAD: begin
                  if (!found_ff) begin
                     status_ff <= ntmr_pkg::ST_UNKNOWN;
                  end else if (!load_ok) begin
                     status_ff <= ntmr_pkg::ST_NOT_FOUND;
                  end
               end
               ntmr_pkg::FUNC_SET: begin
                  if (!found_ff) begin
                     status_ff <= ntmr_pkg::ST_UNKNOWN;
                  end
               end
               ntmr_pkg::FUNC_COMPUTE: begin
                  if (!found_ff) begin
                     status_ff <= ntmr_pkg::ST_UNKNOWN;
                  end else begin
                     acc_ff <= {{(ntmr_pkg::ACC_W-ntmr_pkg::VAL_W-ntmr_pkg::FRAC_W)
                                 {bias_mem[slot_ff][ntmr_pkg::VAL_W-1]}},
                                bias_mem[slot_ff], {ntmr_pkg::FRAC_W{1'b0}}};
                  end
               end
               default: begin
               end
            endcase
         end
         // clear sweep over the new row
         if (cmd.clr_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         // multiply accumulate pipeline
         if (cmd.mac_step) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            if (issue) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (v1_ff) begin
               prod_ff <= mult;
            end
            if (v2_ff) begin
               acc_ff <= acc_ff + ntmr_pkg::ACC_W'(prod_ff);
            end
         end
         if (cmd.pos_start) begin
            idx_ff    <= '0;
            v1_ff     <= 1'b0;
            v2_ff     <= 1'b0;
            pfound_ff <= 1'b0;
         end
         // source search, highest match wins
         if (cmd.pos_step) begin
            v1_ff <= issue;
            if (issue) begin
               idx_ff  <= idx_ff + 1'b1;
               piss_ff <= idx_ff;
            end
            if (v1_ff && (rd_src_ff == src_ff)) begin
               pfound_ff <= 1'b1;
               pidx_ff   <= piss_ff;
            end
         end
         // result registers
         if (cmd.resp_load) begin
            out_status_ff <= ((func_ff == ntmr_pkg::FUNC_SET) && found_ff && !pfound_ff)
                             ? ntmr_pkg::ST_NOT_FOUND : status_ff;
            out_result_ff <= result;
            out_known_ff  <= found_ff ? slot_cnt : '0;
            out_req_ff    <= found_ff && pfound_ff;
         end
      end
   end

   // slot table writes on define
   always_ff @(posedge clock) begin
      if (cmd.exec && (func_ff == ntmr_pkg::FUNC_DEFINE) && !full) begin
         id_mem[count_ff[SW-1:0]]   <= nid_ff;
         cnt_mem[count_ff[SW-1:0]]  <= cnt_ff;
         bias_mem[count_ff[SW-1:0]] <= val_ff;
      end
   end

   // weight and source memories
   always_ff @(posedge clock) begin
      if (cmd.exec && (func_ff == ntmr_pkg::FUNC_LOAD) && load_ok) begin
         w_mem[addr] <= val_ff;
         s_mem[addr] <= src_ff;
      end
      rd_w_ff   <= w_mem[addr];
      rd_src_ff <= s_mem[addr];
   end

   // input value memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         v_mem[addr] <= '0;
      end else if (cmd.resp_load && set_ok) begin
         v_mem[addr] <= val_ff;
      end
      rd_val_ff <= v_mem[addr];
   end

   assign rsp_status            = out_status_ff;
   assign rsp_neuron_output     = out_result_ff;
   assign rsp_known_input_count = out_known_ff;
   assign rsp_input_required    = out_req_ff;

endmodule

[src/ntmr_ctrl.sv]
module ntmr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ntmr_pkg::ntmr_cmd_type  cmd,
   input  ntmr_pkg::ntmr_stat_type stat
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SLOT = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_CLR  = 3'd3;
   localparam logic [2:0] S_MAC  = 3'd4;
   localparam logic [2:0] S_POS  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SLOT;
            end
         end
         S_SLOT: begin
            if (stat.slot_done) begin
               state_in = S_EXEC;
            end else begin
               cmd.slot_step = 1'b1;
            end
         end
         S_EXEC: begin
            // execute also clears the scan index for the next phase
            cmd.exec = 1'b1;
            if (stat.go_clr) begin
               state_in = S_CLR;
            end else if (stat.go_mac) begin
               state_in = S_MAC;
            end else begin
               state_in = S_POS;
            end
         end
         S_CLR: begin
            if (stat.clr_done) begin
               cmd.pos_start = 1'b1;
               state_in      = S_POS;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_MAC: begin
            if (stat.mac_done) begin
               cmd.pos_start = 1'b1;
               state_in      = S_POS;
            end else begin
               cmd.mac_step = 1'b1;
            end
         end
         S_POS: begin
            if (stat.pos_done) begin
               state_in = S_FIN;
            end else begin
               cmd.pos_step = 1'b1;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/neuron_table_mac_relu_core.sv]
// Neuron table with weighted sum and relu.
// Input channel req_*: one item per handshake (req_valid and req_ready high at a
// rising edge). req_func picks clear all, define neuron, load weight, set input
// or compute. Result channel rsp_*: exactly one item per input item, in order.
// Steps per item: accept, slot search over the defined neurons, execute; then a
// define that finds room clears the new input row, a compute on a known neuron
// runs the multiply accumulate, and every item runs a source search over the
// neuron's inputs and then loads the result.
// The item rate is set by these sequential scans over the one-port memories.
// Items are taken one at a time: req_ready is high only while the block waits.
// The result sits in an output register, so a new item is accepted while the
// receiver stalls; that item finishes and then waits for the register to drain.
// Reset (synchronous, active high) empties the table and drops any pending result.
module neuron_table_mac_relu_core #(
   parameter int NUM_SLOTS  = ntmr_pkg::MAX_NEURON_SLOTS,
   parameter int NUM_INPUTS = ntmr_pkg::MAX_INPUTS_PER_NEURON
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ntmr_pkg::FUNC_W-1:0]        req_func,
   input  logic [ntmr_pkg::ID_W-1:0]          req_neuron_id,
   input  logic [ntmr_pkg::CNT_W-1:0]         req_input_count,
   input  logic [ntmr_pkg::POS_W-1:0]         req_position,
   input  logic [ntmr_pkg::ID_W-1:0]          req_source_id,
   input  logic signed [ntmr_pkg::VAL_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ntmr_pkg::STAT_W-1:0]        rsp_status,
   output logic [ntmr_pkg::OUT_W-1:0]         rsp_neuron_output,
   output logic [ntmr_pkg::CNT_W-1:0]         rsp_known_input_count,
   output logic                               rsp_input_required
);

   ntmr_pkg::ntmr_cmd_type  cmd;
   ntmr_pkg::ntmr_stat_type stat;

   // sequencer
   ntmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // table, memories and accumulator
   ntmr_dp #(
      .NS (NUM_SLOTS),
      .NI (NUM_INPUTS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_func              (req_func),
      .req_neuron_id         (req_neuron_id),
      .req_input_count       (req_input_count),
      .req_position          (req_position),
      .req_source_id         (req_source_id),
      .req_value             (req_value),
      .rsp_status            (rsp_status),
      .rsp_neuron_output     (rsp_neuron_output),
      .rsp_known_input_count (rsp_known_input_count),
      .rsp_input_required    (rsp_input_required)
   );

endmodule

[src/ntmr_chk.sv]
module ntmr_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ntmr_pkg::STAT_W-1:0]       rsp_status,
   input logic [ntmr_pkg::OUT_W-1:0]        rsp_neuron_output,
   input logic [ntmr_pkg::CNT_W-1:0]        rsp_known_input_count,
   input logic                              rsp_input_required
);

   // no result survives reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while busy");

   // stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_neuron_output)))
      else $error("stalled result changed");

   // failed items give no output value
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ntmr_pkg::ST_OK)) |-> (rsp_neuron_output == '0))
      else $error("output on failed item");

   // a required source implies a known neuron with inputs
   a_req_known : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_input_required) |-> (rsp_known_input_count != '0))
      else $error("required input on unknown neuron");

endmodule

bind neuron_table_mac_relu_core ntmr_chk u_chk (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_status            (rsp_status),
   .rsp_neuron_output     (rsp_neuron_output),
   .rsp_known_input_count (rsp_known_input_count),
   .rsp_input_required    (rsp_input_required)
);
